/* rtl/vt100_escape_cursor_parser_top_assert.svh */
// Assertion macros for the cursor parser.
`ifndef VT100_ESCAPE_CURSOR_PARSER_TOP_ASSERT_SVH
`define VT100_ESCAPE_CURSOR_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VECP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vecp assertion failed");

// Next-cycle implication.
`define VECP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vecp assertion failed");

`endif

/* rtl/vecp_pkg.sv */
`default_nettype none

package vecp_pkg;

  localparam int unsigned CharW = 16;
  localparam int unsigned CurW  = 12;

  localparam logic [CurW-1:0] CurMax = {CurW{1'b1}};

  localparam logic [CharW-1:0] ChEsc   = 16'h001B;
  localparam logic [CharW-1:0] ChLf    = 16'h000A;
  localparam logic [CharW-1:0] ChCr    = 16'h000D;
  localparam logic [CharW-1:0] ChBrack = 16'h005B;
  localparam logic [CharW-1:0] ChSemi  = 16'h003B;
  localparam logic [CharW-1:0] ChZero  = 16'h0030;
  localparam logic [CharW-1:0] ChNine  = 16'h0039;
  localparam logic [CharW-1:0] ChUpM   = 16'h004D;
  localparam logic [CharW-1:0] ChSeven = 16'h0037;
  localparam logic [CharW-1:0] ChEight = 16'h0038;
  localparam logic [CharW-1:0] ChUpA   = 16'h0041;
  localparam logic [CharW-1:0] ChUpZ   = 16'h005A;
  localparam logic [CharW-1:0] ChLoA   = 16'h0061;
  localparam logic [CharW-1:0] ChLoZ   = 16'h007A;

  localparam logic [7:0] FinUpA = 8'h41;
  localparam logic [7:0] FinUpB = 8'h42;
  localparam logic [7:0] FinUpC = 8'h43;
  localparam logic [7:0] FinUpD = 8'h44;
  localparam logic [7:0] FinUpE = 8'h45;
  localparam logic [7:0] FinUpF = 8'h46;
  localparam logic [7:0] FinUpG = 8'h47;
  localparam logic [7:0] FinUpH = 8'h48;
  localparam logic [7:0] FinLoD = 8'h64;
  localparam logic [7:0] FinLoF = 8'h66;
  localparam logic [7:0] FinLoS = 8'h73;
  localparam logic [7:0] FinLoU = 8'h75;

  typedef enum logic [2:0] {
    MODE_GROUND = 3'b001,
    MODE_ESC    = 3'b010,
    MODE_CSI    = 3'b100
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [CurW-1:0] first_param;
    logic [CurW-1:0] second_param;
    logic            param_index;
    logic [CurW-1:0] col;
    logic [CurW-1:0] row;
    logic [CurW-1:0] saved_col;
    logic [CurW-1:0] saved_row;
  } state_t;

  function automatic logic [CurW-1:0] sat_add(input logic [CurW-1:0] a,
                                              input logic [CurW-1:0] b);
    logic [CurW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CurW] ? CurMax : s[CurW-1:0];
  endfunction

  function automatic logic [CurW-1:0] sat_sub(input logic [CurW-1:0] a,
                                              input logic [CurW-1:0] b);
    return (b > a) ? '0 : (a - b);
  endfunction

  function automatic logic [CurW-1:0] at_least_one(input logic [CurW-1:0] v);
    return (v == '0) ? CurW'(1) : v;
  endfunction

  function automatic logic is_printable(input logic [CharW-1:0] c);
    return ((c >= 16'h0020) && (c <= 16'h007E)) || (c >= 16'h00A0);
  endfunction

  function automatic logic [CurW-1:0] add_digit(input logic [CurW-1:0] p,
                                                input logic [3:0] d);
    logic [CharW-1:0] s;
    s = ({4'b0, p} << 3) + ({4'b0, p} << 1) + {12'b0, d};
    return (s > {4'b0, CurMax}) ? CurMax : s[CurW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/vecp_step.sv */
`default_nettype none

module vecp_step (
  input  vecp_pkg::state_t         state_i,
  input  logic [15:0]              char_i,
  output vecp_pkg::state_t         state_o,
  output logic                     text_valid_o,
  output logic [15:0]              text_char_o
);
  import vecp_pkg::*;

  logic [CurW-1:0] n;
  logic            is_digit;
  logic            is_letter;
  logic [7:0]      fin;

  assign n         = at_least_one(state_i.first_param);
  assign is_digit  = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_letter = ((char_i >= ChUpA) && (char_i <= ChUpZ)) ||
                     ((char_i >= ChLoA) && (char_i <= ChLoZ));
  assign fin       = char_i[7:0];

  always_comb begin
    state_o      = state_i;
    text_valid_o = 1'b0;
    text_char_o  = '0;
    unique case (state_i.mode)
      MODE_ESC: begin
        state_o.mode = MODE_GROUND;
        if (char_i == ChEsc) begin
          state_o.mode         = MODE_ESC;
          state_o.first_param  = '0;
          state_o.second_param = '0;
          state_o.param_index  = 1'b0;
        end else if (char_i == ChBrack) begin
          state_o.mode         = MODE_CSI;
          state_o.first_param  = '0;
          state_o.second_param = '0;
          state_o.param_index  = 1'b0;
        end else if (char_i == ChUpM) begin
          state_o.row = sat_sub(state_i.row, CurW'(1));
        end else if (char_i == ChSeven) begin
          state_o.saved_col = state_i.col;
          state_o.saved_row = state_i.row;
        end else if (char_i == ChEight) begin
          state_o.col = state_i.saved_col;
          state_o.row = state_i.saved_row;
        end
      end
      MODE_CSI: begin
        if (char_i == ChEsc) begin
          state_o.mode         = MODE_ESC;
          state_o.first_param  = '0;
          state_o.second_param = '0;
          state_o.param_index  = 1'b0;
        end else if (is_digit) begin
          if (!state_i.param_index) begin
            state_o.first_param = add_digit(state_i.first_param, char_i[3:0]);
          end else begin
            state_o.second_param = add_digit(state_i.second_param, char_i[3:0]);
          end
        end else if (char_i == ChSemi) begin
          state_o.param_index = 1'b1;
        end else if (is_letter) begin
          state_o.mode         = MODE_GROUND;
          state_o.first_param  = '0;
          state_o.second_param = '0;
          state_o.param_index  = 1'b0;
          unique case (fin)
            FinUpA, FinUpF: state_o.row = sat_sub(state_i.row, n);
            FinUpB, FinUpE: state_o.row = sat_add(state_i.row, n);
            FinUpC:         state_o.col = sat_add(state_i.col, n);
            FinUpD:         state_o.col = sat_sub(state_i.col, n);
            FinUpG:         state_o.col = n;
            FinLoD:         state_o.row = n;
            FinUpH, FinLoF: begin
              state_o.row = n;
              state_o.col = at_least_one(state_i.second_param);
            end
            FinLoS: begin
              state_o.saved_col = state_i.col;
              state_o.saved_row = state_i.row;
            end
            FinLoU: begin
              state_o.col = state_i.saved_col;
              state_o.row = state_i.saved_row;
            end
            default: ;
          endcase
        end
      end
      default: begin
        state_o.mode = MODE_GROUND;
        if (char_i == ChEsc) begin
          state_o.mode         = MODE_ESC;
          state_o.first_param  = '0;
          state_o.second_param = '0;
          state_o.param_index  = 1'b0;
        end else if (char_i == ChLf) begin
          state_o.row = sat_add(state_i.row, CurW'(1));
        end else if (char_i == ChCr) begin
          state_o.col = '0;
        end else if (is_printable(char_i)) begin
          text_valid_o = 1'b1;
          text_char_o  = char_i;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/vt100_escape_cursor_parser_top.sv */
// VT100/ANSI cursor parser.
// Input channel: one 16-bit character per transfer on char_code_i, qualified
// by in_valid_i and held off by in_stall_o. Output channel: one result per
// character (text_valid_o, text_char_o, column_o, row_o) on out_valid_o,
// held off by out_stall_i.
// A character accepted into the input register passes through the parse step
// into the result register and from there to the outputs.
// Throughput: one character per cycle while the receiver does not stall; the
// parse step is a single pass of compare, add and saturate logic between the
// two registers; cursor state and result register load in the same cycle.
// Reset clears the valid flags of both stages, sets the parse mode to ground
// and clears the cursor, saved cursor and parameters to zero.
// When the receiver stalls, the result holds; the input register keeps its
// character and in_stall_o rises only once both stages are full.
`default_nettype none

module vt100_escape_cursor_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        text_valid_o,
  output logic [15:0] text_char_o,
  output logic [11:0] column_o,
  output logic [11:0] row_o
);
  import vecp_pkg::*;

  logic        in_valid_q;
  logic [15:0] char_q;
  logic        out_valid_q;
  logic        text_valid_q;
  logic [15:0] text_char_q;
  logic [11:0] column_q;
  logic [11:0] row_q;
  state_t      state_q;
  state_t      state_d;
  logic        text_valid_d;
  logic [15:0] text_char_d;
  logic        advance;
  logic        in_xfer;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  vecp_step u_step (
    .state_i      (state_q),
    .char_i       (char_q),
    .state_o      (state_d),
    .text_valid_o (text_valid_d),
    .text_char_o  (text_char_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: MODE_GROUND, default: '0};
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      char_q <= char_code_i;
    end
    if (advance) begin
      text_valid_q <= text_valid_d;
      text_char_q  <= text_char_d;
      column_q     <= state_d.col;
      row_q        <= state_d.row;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign text_valid_o = text_valid_q;
  assign text_char_o  = text_char_q;
  assign column_o     = column_q;
  assign row_o        = row_q;

`include "vt100_escape_cursor_parser_top_assert.svh"

  `VECP_ASSERT_NEXT(a_step_loads_result, clk_i, rst_ni, advance, out_valid_o)
  `VECP_ASSERT_NOW(a_cursor_matches, clk_i, rst_ni, out_valid_o,
                   (column_o == state_q.col) && (row_o == state_q.row))
  `VECP_ASSERT_NOW(a_text_char_zero, clk_i, rst_ni, out_valid_o && !text_valid_o,
                   text_char_o == '0)

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;
  import vecp_pkg::*;

  localparam logic [15:0] PrintLo = 16'h0020;
  localparam logic [15:0] PrintHi = 16'h007E;
  localparam logic [15:0] HighLo  = 16'h00A0;
  localparam int unsigned RandItems  = 800;
  localparam int unsigned HoldStartA = 250;
  localparam int unsigned HoldStartB = 900;
  localparam int unsigned HoldLen    = 150;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned WatchLimit = 2000;
  localparam logic [12*8-1:0] FinalSet = {FinUpA, FinUpB, FinUpC, FinUpD, FinUpE, FinUpF,
                                          FinUpG, FinUpH, FinLoD, FinLoF, FinLoS, FinLoU};

  typedef struct packed {
    logic        text_valid;
    logic [15:0] text_char;
    logic [11:0] column;
    logic [11:0] row;
  } cursor_rec_t;

  typedef struct {
    logic [15:0] code;
    bit          drain;
  } char_item_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] char_code_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        text_valid_o;
  logic [15:0] text_char_o;
  logic [11:0] column_o;
  logic [11:0] row_o;

  char_item_t  char_q[$];
  cursor_rec_t cursor_q[$];

  mode_e       p_mode;
  logic [11:0] p_first, p_second, p_col, p_row, p_saved_col, p_saved_row;
  logic        p_index;

  int unsigned mismatch_cnt = 0;
  int unsigned idle_cnt = 0;
  bit          timed_out = 1'b0;

  int unsigned sent_cnt, done_cnt, burst_left, gap_left;
  int unsigned rx_cycle, phase_left, stall_pct, hold_left;

  vt100_escape_cursor_parser_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_valid_o(text_valid_o),
    .text_char_o (text_char_o),
    .column_o    (column_o),
    .row_o       (row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [11:0] cur_add(input logic [11:0] a, input int unsigned n);
    int unsigned s;
    s = 32'(a) + n;
    return (s > 32'(CurMax)) ? CurMax : s[11:0];
  endfunction

  function automatic logic [11:0] cur_sub(input logic [11:0] a, input logic [11:0] n);
    return (n > a) ? 12'd0 : a - n;
  endfunction

  function automatic void clear_params();
    p_first  = '0;
    p_second = '0;
    p_index  = 1'b0;
  endfunction

  function automatic cursor_rec_t parse_char(input logic [15:0] c);
    cursor_rec_t r;
    logic [11:0] nval;
    int unsigned acc;
    r.text_valid = 1'b0;
    r.text_char  = '0;
    case (p_mode)
      MODE_ESC: begin
        p_mode = MODE_GROUND;
        if (c == ChEsc) begin
          p_mode = MODE_ESC;
          clear_params();
        end else if (c == ChBrack) begin
          p_mode = MODE_CSI;
          clear_params();
        end else if (c == ChUpM) begin
          p_row = cur_sub(p_row, 12'd1);
        end else if (c == ChSeven) begin
          p_saved_col = p_col;
          p_saved_row = p_row;
        end else if (c == ChEight) begin
          p_col = p_saved_col;
          p_row = p_saved_row;
        end
      end
      MODE_CSI: begin
        if (c == ChEsc) begin
          p_mode = MODE_ESC;
          clear_params();
        end else if (c >= ChZero && c <= ChNine) begin
          acc = 32'(p_index ? p_second : p_first);
          acc = acc * 10 + 32'(c - ChZero);
          if (p_index) p_second = cur_add(12'd0, acc);
          else p_first = cur_add(12'd0, acc);
        end else if (c == ChSemi) begin
          p_index = 1'b1;
        end else if ((c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ)) begin
          nval = (p_first == '0) ? 12'd1 : p_first;
          case (c[7:0])
            FinUpA, FinUpF: p_row = cur_sub(p_row, nval);
            FinUpB, FinUpE: p_row = cur_add(p_row, 32'(nval));
            FinUpC: p_col = cur_add(p_col, 32'(nval));
            FinUpD: p_col = cur_sub(p_col, nval);
            FinUpG: p_col = nval;
            FinLoD: p_row = nval;
            FinUpH, FinLoF: begin
              p_row = nval;
              p_col = (p_second == '0) ? 12'd1 : p_second;
            end
            FinLoS: begin
              p_saved_col = p_col;
              p_saved_row = p_row;
            end
            FinLoU: begin
              p_col = p_saved_col;
              p_row = p_saved_row;
            end
            default: ;
          endcase
          p_mode = MODE_GROUND;
          clear_params();
        end
      end
      default: begin
        p_mode = MODE_GROUND;
        if (c == ChEsc) begin
          p_mode = MODE_ESC;
          clear_params();
        end else if (c == ChLf) begin
          p_row = cur_add(p_row, 1);
        end else if (c == ChCr) begin
          p_col = '0;
        end else if ((c >= PrintLo && c <= PrintHi) || c >= HighLo) begin
          r.text_valid = 1'b1;
          r.text_char  = c;
        end
      end
    endcase
    r.column = p_col;
    r.row    = p_row;
    return r;
  endfunction

  task automatic send(input logic [15:0] c);
    char_item_t it;
    it.code  = c;
    it.drain = 1'b0;
    char_q.push_back(it);
  endtask

  task automatic send_digits(input int unsigned count);
    repeat (count) send(ChZero + 16'($urandom_range(0, 9)));
  endtask

  task automatic send_csi();
    logic [15:0] c;
    int unsigned k;
    send(ChEsc);
    send(ChBrack);
    send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 2));
    if ($urandom_range(0, 1)) begin
      send(ChSemi);
      send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) begin
        send(ChSemi);
        send_digits($urandom_range(0, 2));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      do begin
        c = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h00FF))
                                 : 16'($urandom_range(0, 16'hFFFF));
      end while ((c >= ChZero && c <= ChNine) || c == ChSemi || c == ChEsc ||
                 (c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ));
      send(c);
    end
    if ($urandom_range(0, 15) == 0) begin
      send(ChEsc);
    end else if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(0, 51);
      send((k < 26) ? ChUpA + 16'(k) : ChLoA + 16'(k - 26));
    end else begin
      k = $urandom_range(0, 11);
      send({8'h00, FinalSet[8*k +: 8]});
    end
  endtask

  initial begin
    int unsigned base, idx;
    char_item_t it;

    send(16'h0000);
    send(16'hFFFF);
    send(PrintHi + 16'd1);
    send(HighLo);
    send(ChLf);
    send(ChCr);
    send(ChEsc); send(ChBrack);
    repeat (4) send(ChZero + 16'd9);
    send({8'h00, FinUpC});
    send(ChEsc); send(ChSeven);
    send(ChEsc); send(ChBrack); send(ChZero + 16'd5); send(ChSemi);
    send(ChZero + 16'd7); send(ChSemi); send(ChZero + 16'd3); send({8'h00, FinUpH});
    send(ChEsc); send(ChBrack); send(ChZero + 16'd2); send(16'h0001);
    send(ChEsc); send(ChBrack); send({8'h00, FinUpA});
    send(ChEsc); send(ChUpM);
    send(ChEsc); send(16'h0005);
    send(ChEsc); send(ChEight);

    base = char_q.size();
    while (char_q.size() < base + RandItems) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 6))
            send(($urandom_range(0, 3) == 0) ? 16'($urandom_range(HighLo, 16'hFFFF))
                                             : 16'($urandom_range(PrintLo, PrintHi)));
        end
        4, 5: send($urandom_range(0, 1) ? ChLf : ChCr);
        6, 7: begin
          send(ChEsc);
          case ($urandom_range(0, 5))
            0: send(ChUpM);
            1: send(ChSeven);
            2: send(ChEight);
            3: send(ChEsc);
            default: send(16'($urandom_range(0, 16'hFFFF)));
          endcase
        end
        15: send(16'($urandom_range(0, 16'hFFFF)));
        default: send_csi();
      endcase
    end

    for (idx = base; idx < char_q.size(); idx += 300) begin
      it = char_q[idx];
      it.drain = 1'b1;
      char_q[idx] = it;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (!timed_out && (char_q.size() != 0 || cursor_q.size() != 0));
    repeat (TailCycles) @(negedge clk_i);

    if (!timed_out && mismatch_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      char_code_i <= '0;
      sent_cnt   = 0;
      done_cnt   = 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        void'(char_q.pop_front());
        sent_cnt++;
      end
      if (out_valid_o && !out_stall_i) done_cnt++;
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (char_q.size() == 0 || (char_q[0].drain && sent_cnt != done_cnt)) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i  <= 1'b1;
          char_code_i <= char_q[0].code;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_cycle   = 0;
      phase_left = 0;
      stall_pct  = 0;
      hold_left  = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle == HoldStartA || rx_cycle == HoldStartB) hold_left = HoldLen;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 120);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end else begin
          phase_left--;
        end
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_rec_t want, seen;
    if (!rst_ni) begin
      p_mode      = MODE_GROUND;
      p_col       = '0;
      p_row       = '0;
      p_saved_col = '0;
      p_saved_row = '0;
      clear_params();
    end else begin
      if (in_valid_i && !in_stall_o) cursor_q.push_back(parse_char(char_code_i));
      if (out_valid_o && !out_stall_i) begin
        seen = '{text_valid_o, text_char_o, column_o, row_o};
        if (cursor_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected transfer: tv=%0b ch=%h col=%0d row=%0d",
                     seen.text_valid, seen.text_char, seen.column, seen.row);
        end else begin
          want = cursor_q.pop_front();
          if (seen.text_valid !== want.text_valid || seen.text_char !== want.text_char ||
              seen.column !== want.column || seen.row !== want.row) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"bad result: exp tv=%0b ch=%h col=%0d row=%0d, ",
                        "got tv=%0b ch=%h col=%0d row=%0d"},
                       want.text_valid, want.text_char, want.column, want.row,
                       seen.text_valid, seen.text_char, seen.column, seen.row);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WatchLimit) timed_out = 1'b1;
    end
  end

endmodule

`default_nettype wire
